// ===== design/dual_valve_motor_sequencer_macros.svh =====
// Assertion macros used by the checker file.
// Each macro samples on clk_i and is disabled while rst_ni is low.
`ifndef DUAL_VALVE_MOTOR_SEQUENCER_MACROS_SVH
`define DUAL_VALVE_MOTOR_SEQUENCER_MACROS_SVH

// Same-cycle implication
`define DVMS_ASSERT_IMPL(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication
`define DVMS_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/dvms_pkg.sv =====
`timescale 1ns / 1ps

package dvms_pkg;

  localparam int TICK_W  = 16;
  localparam int PIN_W   = 7;
  localparam int CFG_IDX_W = 2;

  // Valve position codes
  typedef enum logic [1:0] {
    POS_CLOSED = 2'd0,
    POS_OPEN   = 2'd1,
    POS_MIDDLE = 2'd2
  } pos_e;

  // Input transaction modes
  localparam logic [1:0] MODE_TICK = 2'd0;
  localparam logic [1:0] MODE_MOVE = 2'd1;
  localparam logic [1:0] MODE_CAL  = 2'd2;

  // Move command codes
  localparam logic [1:0] CMD_OPEN_V1  = 2'd0;
  localparam logic [1:0] CMD_CLOSE_V1 = 2'd1;
  localparam logic [1:0] CMD_OPEN_V2  = 2'd2;
  localparam logic [1:0] CMD_CLOSE_V2 = 2'd3;

  // Result codes
  localparam logic [1:0] RES_NONE    = 2'd0;
  localparam logic [1:0] RES_MOVED   = 2'd1;
  localparam logic [1:0] RES_TIMEOUT = 2'd2;
  localparam logic [1:0] RES_ALREADY = 2'd3;

  // Motor direction codes
  localparam logic [1:0] DIR_CLOSE = 2'd0;
  localparam logic [1:0] DIR_OPEN  = 2'd1;
  localparam logic [1:0] DIR_BRAKE = 2'd2;
  localparam logic [1:0] DIR_STOP  = 2'd3;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_BACKOFF = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BRAKE   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT = 2'd2;

  localparam logic [TICK_W-1:0] BACKOFF_RST = 16'd100;
  localparam logic [TICK_W-1:0] BRAKE_RST   = 16'd50;
  localparam logic [TICK_W-1:0] TIMEOUT_RST = 16'd10000;

  typedef struct packed {
    logic [TICK_W-1:0] backoff;
    logic [TICK_W-1:0] brake;
    logic [TICK_W-1:0] timeout;
  } dvms_cfg_t;

  typedef struct packed {
    logic [PIN_W-1:0] drive_pins;
    pos_e             valve1_position;
    pos_e             valve2_position;
    logic             busy_res;
    logic [1:0]       result_code;
    logic             error_flag;
    logic             calibrated;
  } dvms_result_t;

  // Decode one limit switch pair
  function automatic pos_e decode_pair(input logic s1, input logic s2);
    pos_e p;
    if (!s1 && s2) begin
      p = POS_CLOSED;
    end else if (s1 && !s2) begin
      p = POS_OPEN;
    end else begin
      p = POS_MIDDLE;
    end
    return p;
  endfunction

  // Apply a direction to one valve's bridge inputs
  function automatic logic [PIN_W-1:0] set_dir(input logic [PIN_W-1:0] pins,
                                               input logic v2,
                                               input logic [1:0] dir);
    logic [PIN_W-1:0] r;
    logic [1:0]       lv;
    logic             drv;
    r   = pins;
    drv = (dir == DIR_CLOSE) || (dir == DIR_OPEN);
    case (dir)
      DIR_CLOSE: lv = 2'b01;
      DIR_OPEN:  lv = 2'b10;
      DIR_BRAKE: lv = 2'b11;
      default:   lv = 2'b00;
    endcase
    if (!v2) begin
      r[2:0] = {drv, lv};
    end else begin
      r[4:3] = lv;
    end
    return r;
  endfunction

  // Standby / sleep enable bit of one driver
  function automatic logic [PIN_W-1:0] sleep_mask(input logic v2);
    return v2 ? 7'h40 : 7'h20;
  endfunction

  // Saturating tick counter increment
  function automatic logic [TICK_W-1:0] sat_inc(input logic [TICK_W-1:0] c);
    return (c == '1) ? c : c + 1'b1;
  endfunction

endpackage

// ===== design/dvms_cfg.sv =====
`timescale 1ns / 1ps

module dvms_cfg (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [dvms_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [dvms_pkg::TICK_W-1:0]   cfg_data_i,
  output dvms_pkg::dvms_cfg_t           cfg_o
);
  import dvms_pkg::*;

  dvms_cfg_t cfg_q;

  // Timing registers; the user writes them only while the sequencer is idle, the block does not enforce it
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.backoff <= BACKOFF_RST;
      cfg_q.brake   <= BRAKE_RST;
      cfg_q.timeout <= TIMEOUT_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        REG_BACKOFF: cfg_q.backoff <= cfg_data_i;
        REG_BRAKE:   cfg_q.brake   <= cfg_data_i;
        REG_TIMEOUT: cfg_q.timeout <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ===== design/dvms_core.sv =====
`timescale 1ns / 1ps

module dvms_core (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      en_i,
  input  logic [1:0]                mode_i,
  input  logic [1:0]                move_i,
  input  logic [3:0]                switches_i,
  input  dvms_pkg::dvms_cfg_t       cfg_i,
  output dvms_pkg::dvms_result_t    res_o
);
  import dvms_pkg::*;

  typedef enum logic [2:0] {
    PH_IDLE       = 3'd0,
    PH_BACKOFF    = 3'd1,
    PH_BRAKE_BACK = 3'd2,
    PH_DRIVE      = 3'd3,
    PH_BRAKE_OK   = 3'd4,
    PH_BRAKE_TO   = 3'd5
  } phase_e;

  phase_e            phase_q, phase_d;
  logic [TICK_W-1:0] cnt_q, cnt_d;
  pos_e              v1_q, v1_d, v2_q, v2_d;
  logic [1:0]        act_q, act_d;
  logic [1:0]        cal_q, cal_d;
  logic              err_q, err_d;
  logic              calib_q, calib_d;
  logic [PIN_W-1:0]  pins_q, pins_d;

  logic [1:0]        res;
  logic              do_cal, do_start, from_cal;
  logic [1:0]        smv;
  logic              cur_v2, cur_open, s_v2, s_open;
  logic [TICK_W-1:0] cnt_inc;
  pos_e              dec1, dec2, s_cur, s_tgt, end_pos;

  assign dec1     = decode_pair(switches_i[0], switches_i[1]);
  assign dec2     = decode_pair(switches_i[2], switches_i[3]);
  assign cur_v2   = act_q[1];
  assign cur_open = ~act_q[0];
  assign cnt_inc  = sat_inc(cnt_q);

  // One step of the sequencer for the transaction in the input register
  always_comb begin
    phase_d  = phase_q;
    cnt_d    = cnt_q;
    v1_d     = v1_q;
    v2_d     = v2_q;
    act_d    = act_q;
    cal_d    = cal_q;
    err_d    = err_q;
    calib_d  = calib_q;
    pins_d   = pins_q;
    res      = RES_NONE;
    do_cal   = 1'b0;
    do_start = 1'b0;
    from_cal = 1'b0;
    smv      = move_i;
    end_pos  = (phase_q == PH_BRAKE_OK) ? (cur_open ? POS_OPEN : POS_CLOSED) : POS_MIDDLE;

    unique case (mode_i)
      MODE_TICK: begin
        unique case (phase_q)
          PH_BACKOFF: begin
            cnt_d = cnt_inc;
            if (cnt_inc >= cfg_i.backoff) begin
              pins_d  = set_dir(pins_q, cur_v2, DIR_BRAKE);
              phase_d = PH_BRAKE_BACK;
              cnt_d   = '0;
            end
          end
          PH_BRAKE_BACK: begin
            cnt_d = cnt_inc;
            if (cnt_inc >= cfg_i.brake) begin
              if (cur_v2) begin
                v2_d = POS_MIDDLE;
              end else begin
                v1_d = POS_MIDDLE;
              end
              pins_d  = set_dir(pins_q, cur_v2, cur_open ? DIR_OPEN : DIR_CLOSE)
                        | sleep_mask(cur_v2);
              phase_d = PH_DRIVE;
              cnt_d   = '0;
            end
          end
          PH_DRIVE: begin
            // target switch goes low when the end stop is reached
            if (!switches_i[{cur_v2, cur_open}]) begin
              pins_d  = set_dir(pins_q, cur_v2, DIR_BRAKE);
              phase_d = PH_BRAKE_OK;
              cnt_d   = '0;
            end else begin
              cnt_d = cnt_inc;
              if (cnt_inc >= cfg_i.timeout) begin
                pins_d  = set_dir(pins_q, cur_v2, DIR_BRAKE);
                phase_d = PH_BRAKE_TO;
                cnt_d   = '0;
              end
            end
          end
          PH_BRAKE_OK, PH_BRAKE_TO: begin
            cnt_d = cnt_inc;
            if (cnt_inc >= cfg_i.brake) begin
              pins_d = set_dir(pins_q, cur_v2, DIR_STOP) & ~sleep_mask(cur_v2);
              if (cur_v2) begin
                v2_d = end_pos;
              end else begin
                v1_d = end_pos;
              end
              if (phase_q == PH_BRAKE_TO) begin
                err_d = 1'b1;
                res   = RES_TIMEOUT;
              end else begin
                res   = RES_MOVED;
              end
              phase_d = PH_IDLE;
              cnt_d   = '0;
              do_cal  = (cal_q != 2'd0);
            end
          end
          default: phase_d = PH_IDLE;
        endcase
      end
      MODE_MOVE: begin
        if (phase_q == PH_IDLE) begin
          do_start = 1'b1;
          smv      = move_i;
        end
      end
      MODE_CAL: begin
        if (phase_q == PH_IDLE) begin
          v1_d  = dec1;
          v2_d  = dec2;
          cal_d = 2'd1;
          if (dec1 != POS_CLOSED) begin
            do_start = 1'b1;
            smv      = CMD_CLOSE_V1;
          end else begin
            do_cal = 1'b1;
          end
        end
      end
      default: ;
    endcase

    // Calibration: after valve 1, open valve 2 if needed, then finish
    if (do_cal) begin
      if (cal_d == 2'd1) begin
        cal_d = 2'd2;
        if (v2_d != POS_OPEN) begin
          do_start = 1'b1;
          smv      = CMD_OPEN_V2;
          from_cal = 1'b1;
        end
      end
      if (!from_cal) begin
        cal_d   = 2'd0;
        calib_d = 1'b1;
      end
    end

    // Move start: decode switches, reject or launch backoff / drive
    s_v2   = smv[1];
    s_open = ~smv[0];
    s_cur  = s_v2 ? dec2 : dec1;
    s_tgt  = s_open ? POS_OPEN : POS_CLOSED;
    if (do_start) begin
      v1_d = dec1;
      v2_d = dec2;
      if (s_cur == s_tgt) begin
        err_d = 1'b1;
        res   = RES_ALREADY;
        if (from_cal) begin
          cal_d   = 2'd0;
          calib_d = 1'b1;
        end
      end else begin
        act_d = smv;
        cnt_d = '0;
        if (s_cur == POS_MIDDLE) begin
          pins_d  = set_dir(pins_d, s_v2, s_open ? DIR_CLOSE : DIR_OPEN) | sleep_mask(s_v2);
          phase_d = PH_BACKOFF;
        end else begin
          if (s_v2) begin
            v2_d = POS_MIDDLE;
          end else begin
            v1_d = POS_MIDDLE;
          end
          pins_d  = set_dir(pins_d, s_v2, s_open ? DIR_OPEN : DIR_CLOSE) | sleep_mask(s_v2);
          phase_d = PH_DRIVE;
        end
      end
    end
  end

  // Sequencer state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      cnt_q   <= '0;
      v1_q    <= POS_MIDDLE;
      v2_q    <= POS_MIDDLE;
      act_q   <= '0;
      cal_q   <= '0;
      err_q   <= 1'b0;
      calib_q <= 1'b0;
      pins_q  <= '0;
    end else if (en_i) begin
      phase_q <= phase_d;
      cnt_q   <= cnt_d;
      v1_q    <= v1_d;
      v2_q    <= v2_d;
      act_q   <= act_d;
      cal_q   <= cal_d;
      err_q   <= err_d;
      calib_q <= calib_d;
      pins_q  <= pins_d;
    end
  end

  // Result of this step, taken from the next state
  always_comb begin
    res_o.drive_pins      = pins_d;
    res_o.valve1_position = v1_d;
    res_o.valve2_position = v2_d;
    res_o.busy_res        = (phase_d != PH_IDLE);
    res_o.result_code     = res;
    res_o.error_flag      = err_d;
    res_o.calibrated      = calib_d;
  end

endmodule

// ===== design/dual_valve_motor_sequencer.sv =====
`timescale 1ns / 1ps
// Path from input transaction to result: input register, step logic, result register.
// Throughput: one transaction per cycle while out_stall_i does not hold the result register.
// Every input transaction (tick or command) yields exactly one result transaction.
// Reset (rst_ni low, asynchronous): valves read middle, motors stopped, flags clear,
// timing registers return to backoff 100, brake 50, timeout 10000 ticks.
module dual_valve_motor_sequencer (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // input channel
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic [1:0]                     mode_i,
  input  logic [1:0]                     move_i,
  input  logic [3:0]                     switches_i,
  // result channel
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [dvms_pkg::PIN_W-1:0]     drive_pins_o,
  output logic [1:0]                     valve1_position_o,
  output logic [1:0]                     valve2_position_o,
  output logic                           busy_res_o,
  output logic [1:0]                     result_code_o,
  output logic                           error_flag_o,
  output logic                           calibrated_o,
  // configuration
  input  logic                           cfg_we_i,
  input  logic [dvms_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [dvms_pkg::TICK_W-1:0]    cfg_data_i
);
  import dvms_pkg::*;

  logic         in_valid_q;
  logic [1:0]   mode_q, move_q;
  logic [3:0]   sw_q;
  logic         out_valid_q;
  dvms_result_t out_q;
  dvms_result_t step_res;
  dvms_cfg_t    cfg;
  logic         advance;

  // Step the held transaction when the result register is free or draining
  assign advance    = in_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = in_valid_q && !advance;

  dvms_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  dvms_core u_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .en_i       (advance),
    .mode_i     (mode_q),
    .move_i     (move_q),
    .switches_i (sw_q),
    .cfg_i      (cfg),
    .res_o      (step_res)
  );

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!in_stall_o && in_valid_i) begin
      mode_q <= mode_i;
      move_q <= move_i;
      sw_q   <= switches_i;
    end
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_q <= step_res;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign drive_pins_o      = out_q.drive_pins;
  assign valve1_position_o = out_q.valve1_position;
  assign valve2_position_o = out_q.valve2_position;
  assign busy_res_o        = out_q.busy_res;
  assign result_code_o     = out_q.result_code;
  assign error_flag_o      = out_q.error_flag;
  assign calibrated_o      = out_q.calibrated;

endmodule

// ===== design/dvms_checker.sv =====
`timescale 1ns / 1ps
`include "dual_valve_motor_sequencer_macros.svh"

module dvms_checker (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       out_valid_o,
  input logic                       out_stall_i,
  input logic [dvms_pkg::PIN_W-1:0] drive_pins_o,
  input logic                       busy_res_o,
  input logic [1:0]                 result_code_o,
  input logic                       error_flag_o
);
  import dvms_pkg::*;

  logic             held;
  logic             rejected;
  logic             err_res;
  logic [PIN_W+2:0] out_word;

  assign held     = out_valid_o && out_stall_i;
  assign rejected = (result_code_o == RES_ALREADY);
  assign err_res  = (result_code_o == RES_TIMEOUT) || rejected;
  assign out_word = {drive_pins_o, result_code_o, busy_res_o};

  // A stalled result transaction stays put
  `DVMS_ASSERT_NEXT(a_out_hold, held, out_valid_o && $stable(out_word), "stalled result changed")

  // A rejected command never leaves a sequence running
  `DVMS_ASSERT_IMPL(a_reject_idle, out_valid_o && rejected, !busy_res_o, "reject while busy")

  // Timeout and reject both raise the sticky error
  `DVMS_ASSERT_IMPL(a_err_set, out_valid_o && err_res, error_flag_o, "error flag not set")

  // With no sequence running, both drivers are stopped and asleep
  `DVMS_ASSERT_IMPL(a_idle_pins, out_valid_o && !busy_res_o, drive_pins_o == '0, "pins active")

endmodule

bind dual_valve_motor_sequencer dvms_checker u_dvms_checker (.*);

// ===== tb/dual_valve_motor_sequencer_test.sv =====
`timescale 1ns / 1ps

module dual_valve_motor_sequencer_test;
  import dvms_pkg::*;

  localparam int CYCLE_LIMIT   = 400000;
  localparam int SETTLE_CYCLES = 6;
  localparam int MAX_REPORTS   = 30;
  localparam int RANDOM_ITEMS  = 1150;
  localparam int RANDOM_PHASES = 6;
  localparam int EPISODE_CAP   = 300;

  // Mode that the block ignores
  localparam logic [1:0] MODE_IGNORED = 2'd3;

  // Calibration progress
  localparam logic [1:0] CAL_OFF    = 2'd0;
  localparam logic [1:0] CAL_VALVE1 = 2'd1;
  localparam logic [1:0] CAL_VALVE2 = 2'd2;

  typedef enum logic [2:0] {
    SEQ_IDLE,
    SEQ_BACKOFF,
    SEQ_BRAKE_BACK,
    SEQ_DRIVE,
    SEQ_BRAKE_OK,
    SEQ_BRAKE_TO
  } seq_phase_e;

  // DUT signals
  logic                 clk_i;
  logic                 rst_ni      = 1'b0;
  logic                 in_valid_i  = 1'b0;
  logic                 in_stall_o;
  logic [1:0]           mode_i      = '0;
  logic [1:0]           move_i      = '0;
  logic [3:0]           switches_i  = '0;
  logic                 out_valid_o;
  logic                 out_stall_i = 1'b0;
  logic [PIN_W-1:0]     drive_pins_o;
  logic [1:0]           valve1_position_o;
  logic [1:0]           valve2_position_o;
  logic                 busy_res_o;
  logic [1:0]           result_code_o;
  logic                 error_flag_o;
  logic                 calibrated_o;
  logic                 cfg_we_i    = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index_i = '0;
  logic [TICK_W-1:0]    cfg_data_i  = '0;

  dual_valve_motor_sequencer dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid_i),
    .in_stall_o        (in_stall_o),
    .mode_i            (mode_i),
    .move_i            (move_i),
    .switches_i        (switches_i),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .drive_pins_o      (drive_pins_o),
    .valve1_position_o (valve1_position_o),
    .valve2_position_o (valve2_position_o),
    .busy_res_o        (busy_res_o),
    .result_code_o     (result_code_o),
    .error_flag_o      (error_flag_o),
    .calibrated_o      (calibrated_o),
    .cfg_we_i          (cfg_we_i),
    .cfg_index_i       (cfg_index_i),
    .cfg_data_i        (cfg_data_i)
  );

  // Sequencer shadow state
  logic [TICK_W-1:0] len_backoff;
  logic [TICK_W-1:0] len_brake;
  logic [TICK_W-1:0] len_timeout;
  seq_phase_e        seq_phase;
  logic [TICK_W-1:0] seq_count;
  pos_e              v1_pos;
  pos_e              v2_pos;
  logic [1:0]        cur_move;
  logic [1:0]        cal_stage;
  logic              err_latched;
  logic              cal_done;
  logic [PIN_W-1:0]  pin_state;

  dvms_result_t pending_status[$];
  int           fail_count   = 0;
  int           sent_items   = 0;
  int           cycle_count  = 0;
  int           gap_mode     = 1;
  int           stall_mode   = 1;
  int           stall_hold   = 0;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------------
  // Sequencer prediction
  // ---------------------------------------------------------------------------

  function automatic pos_e pair_to_pos(input logic s1, input logic s2);
    if (!s1 && s2) begin
      return POS_CLOSED;
    end else if (s1 && !s2) begin
      return POS_OPEN;
    end
    return POS_MIDDLE;
  endfunction

  function automatic logic [PIN_W-1:0] enable_bit(input logic sel_v2);
    return sel_v2 ? 7'h40 : 7'h20;
  endfunction

  task automatic latch_positions(input logic [3:0] sw);
    v1_pos = pair_to_pos(sw[0], sw[1]);
    v2_pos = pair_to_pos(sw[2], sw[3]);
  endtask

  // Bridge levels: close 01, open 10, brake 11, stop 00; v1 pwm while driving
  task automatic drive_valve(input logic sel_v2, input logic [1:0] dir);
    logic [1:0] lv;
    case (dir)
      DIR_CLOSE: lv = 2'b01;
      DIR_OPEN:  lv = 2'b10;
      DIR_BRAKE: lv = 2'b11;
      default:   lv = 2'b00;
    endcase
    if (!sel_v2) begin
      pin_state[2:0] = {(dir == DIR_CLOSE) || (dir == DIR_OPEN), lv};
    end else begin
      pin_state[4:3] = lv;
    end
  endtask

  // Saturating tick count against a phase length
  task automatic count_reached(input logic [TICK_W-1:0] limit, output logic done);
    if (seq_count != '1) seq_count = seq_count + 1'b1;
    done = seq_count >= limit;
  endtask

  task automatic begin_drive();
    logic sel;
    logic opening;
    sel     = cur_move[1];
    opening = !cur_move[0];
    if (sel) v2_pos = POS_MIDDLE;
    else     v1_pos = POS_MIDDLE;
    drive_valve(sel, opening ? DIR_OPEN : DIR_CLOSE);
    pin_state = pin_state | enable_bit(sel);
    seq_phase = SEQ_DRIVE;
    seq_count = '0;
  endtask

  task automatic launch_move(input logic [1:0] mv, input logic [3:0] sw,
                             inout logic [1:0] res, output logic started);
    logic sel;
    logic opening;
    pos_e now_pos;
    sel     = mv[1];
    opening = !mv[0];
    latch_positions(sw);
    now_pos = sel ? v2_pos : v1_pos;
    if (now_pos == (opening ? POS_OPEN : POS_CLOSED)) begin
      err_latched = 1'b1;
      res         = RES_ALREADY;
      started     = 1'b0;
    end else begin
      cur_move = mv;
      if (now_pos == POS_MIDDLE) begin
        // back off away from the target first
        drive_valve(sel, opening ? DIR_CLOSE : DIR_OPEN);
        pin_state = pin_state | enable_bit(sel);
        seq_phase = SEQ_BACKOFF;
        seq_count = '0;
      end else begin
        begin_drive();
      end
      started = 1'b1;
    end
  endtask

  task automatic advance_calibration(input logic [3:0] sw, inout logic [1:0] res);
    logic started;
    started = 1'b0;
    // valve 2 check uses the positions latched when calibration began
    if (cal_stage == CAL_VALVE1) begin
      cal_stage = CAL_VALVE2;
      if (v2_pos != POS_OPEN) launch_move(CMD_OPEN_V2, sw, res, started);
    end
    if (!started) begin
      cal_stage = CAL_OFF;
      cal_done  = 1'b1;
    end
  endtask

  task automatic process_tick(input logic [3:0] sw, inout logic [1:0] res);
    logic       sel;
    logic       opening;
    logic       done;
    logic       ok;
    logic [1:0] tgt;
    pos_e       endpos;
    sel     = cur_move[1];
    opening = !cur_move[0];
    tgt     = {sel, opening};
    case (seq_phase)
      SEQ_BACKOFF: begin
        count_reached(len_backoff, done);
        if (done) begin
          drive_valve(sel, DIR_BRAKE);
          seq_phase = SEQ_BRAKE_BACK;
          seq_count = '0;
        end
      end
      SEQ_BRAKE_BACK: begin
        count_reached(len_brake, done);
        if (done) begin_drive();
      end
      SEQ_DRIVE: begin
        // target switch is tested before the timeout count
        if (!sw[tgt]) begin
          drive_valve(sel, DIR_BRAKE);
          seq_phase = SEQ_BRAKE_OK;
          seq_count = '0;
        end else begin
          count_reached(len_timeout, done);
          if (done) begin
            drive_valve(sel, DIR_BRAKE);
            seq_phase = SEQ_BRAKE_TO;
            seq_count = '0;
          end
        end
      end
      SEQ_BRAKE_OK, SEQ_BRAKE_TO: begin
        count_reached(len_brake, done);
        if (done) begin
          ok     = seq_phase == SEQ_BRAKE_OK;
          endpos = ok ? (opening ? POS_OPEN : POS_CLOSED) : POS_MIDDLE;
          drive_valve(sel, DIR_STOP);
          pin_state = pin_state & ~enable_bit(sel);
          if (sel) v2_pos = endpos;
          else     v1_pos = endpos;
          if (!ok) err_latched = 1'b1;
          res       = ok ? RES_MOVED : RES_TIMEOUT;
          seq_phase = SEQ_IDLE;
          seq_count = '0;
          if (cal_stage != CAL_OFF) advance_calibration(sw, res);
        end
      end
      default: seq_phase = SEQ_IDLE;
    endcase
  endtask

  task automatic sequencer_step(input logic [1:0] mode, input logic [1:0] mv,
                                input logic [3:0] sw, output dvms_result_t r);
    logic [1:0] res;
    logic       started;
    res     = RES_NONE;
    started = 1'b0;
    if (mode == MODE_TICK) begin
      process_tick(sw, res);
    end else if (mode == MODE_MOVE && seq_phase == SEQ_IDLE) begin
      launch_move(mv, sw, res, started);
    end else if (mode == MODE_CAL && seq_phase == SEQ_IDLE) begin
      latch_positions(sw);
      cal_stage = CAL_VALVE1;
      if (v1_pos != POS_CLOSED) launch_move(CMD_CLOSE_V1, sw, res, started);
      if (!started) advance_calibration(sw, res);
    end
    r.drive_pins      = pin_state;
    r.valve1_position = v1_pos;
    r.valve2_position = v2_pos;
    r.busy_res        = seq_phase != SEQ_IDLE;
    r.result_code     = res;
    r.error_flag      = err_latched;
    r.calibrated      = cal_done;
  endtask

  // ---------------------------------------------------------------------------
  // Stimulus and checking
  // ---------------------------------------------------------------------------

  // Mostly short idle stretches, now and then a long one
  function automatic int idle_length(input int idle_mode);
    int pick;
    if (idle_mode == 0) return 0;
    pick = $urandom_range(0, 99);
    if (pick < 65) return 0;
    if (pick < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic logic [1:0] pair_levels(input pos_e p);
    case (p)
      POS_CLOSED: return 2'b10;
      POS_OPEN:   return 2'b01;
      default:    return 2'b11;
    endcase
  endfunction

  function automatic logic [3:0] valve_switches(input pos_e p1, input pos_e p2);
    return {pair_levels(p2), pair_levels(p1)};
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    fail_count++;
    if (fail_count <= MAX_REPORTS) begin
      $display("%0t ns %s: got %0h, expected %0h", $time, what, got, want);
    end
  endtask

  // One input transaction; prediction at the accepting edge
  task automatic send_item(input logic [1:0] mode, input logic [1:0] mv,
                           input logic [3:0] sw);
    int           gap;
    dvms_result_t r;
    gap = idle_length(gap_mode);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    mode_i     <= mode;
    move_i     <= mv;
    switches_i <= sw;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    sent_items++;
    sequencer_step(mode, mv, sw, r);
    pending_status.push_back(r);
  endtask

  task automatic wait_for_results();
    in_valid_i <= 1'b0;
    while (pending_status.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                input logic [TICK_W-1:0] value);
    wait_for_results();
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= value;
    @(posedge clk_i);
    case (idx)
      REG_BACKOFF: len_backoff = value;
      REG_BRAKE:   len_brake   = value;
      REG_TIMEOUT: len_timeout = value;
      default: ;
    endcase
    cfg_we_i <= 1'b0;
  endtask

  // Receiver stall pattern
  always @(posedge clk_i) begin : stall_driver
    int n;
    if (stall_hold > 0) begin
      stall_hold--;
      out_stall_i <= 1'b1;
    end else begin
      n = idle_length(stall_mode);
      if (n > 0) begin
        stall_hold = n - 1;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  // Compare each result transaction with the oldest prediction
  always @(posedge clk_i) begin : result_monitor
    dvms_result_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_status.size() == 0) begin
        report_mismatch("unexpected result", drive_pins_o, 0);
      end else begin
        want = pending_status.pop_front();
        if (drive_pins_o !== want.drive_pins)
          report_mismatch("drive_pins", drive_pins_o, want.drive_pins);
        if (valve1_position_o !== want.valve1_position)
          report_mismatch("valve1_position", valve1_position_o, want.valve1_position);
        if (valve2_position_o !== want.valve2_position)
          report_mismatch("valve2_position", valve2_position_o, want.valve2_position);
        if (busy_res_o !== want.busy_res)
          report_mismatch("busy_res", busy_res_o, want.busy_res);
        if (result_code_o !== want.result_code)
          report_mismatch("result_code", result_code_o, want.result_code);
        if (error_flag_o !== want.error_flag)
          report_mismatch("error_flag", error_flag_o, want.error_flag);
        if (calibrated_o !== want.calibrated)
          report_mismatch("calibrated", calibrated_o, want.calibrated);
      end
    end
  end

  initial begin : watchdog
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("dual_valve_motor_sequencer: mismatch");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Reset timing values, ignored mode, idle tick, rejected moves
  task automatic test_idle_and_rejects();
    send_item(MODE_IGNORED, CMD_CLOSE_V2, 4'hA);
    send_item(MODE_TICK, CMD_OPEN_V1, 4'h5);
    send_item(MODE_MOVE, CMD_OPEN_V1, valve_switches(POS_OPEN, POS_MIDDLE));
    send_item(MODE_MOVE, CMD_CLOSE_V2, valve_switches(POS_MIDDLE, POS_CLOSED));
  endtask

  // Backoff from middle, success, direct drive, busy commands, timeout
  task automatic test_move_outcomes();
    write_register(REG_BACKOFF, 16'd1);
    write_register(REG_BRAKE, 16'd1);
    write_register(REG_TIMEOUT, 16'd3);
    send_item(MODE_MOVE, CMD_OPEN_V1, 4'b1000);
    send_item(MODE_TICK, CMD_OPEN_V1, 4'hF);
    send_item(MODE_TICK, CMD_OPEN_V1, 4'hF);
    send_item(MODE_TICK, CMD_OPEN_V1, 4'hF);
    send_item(MODE_TICK, CMD_OPEN_V1, 4'b1101);
    send_item(MODE_TICK, CMD_OPEN_V1, 4'h0);
    send_item(MODE_MOVE, CMD_CLOSE_V2, valve_switches(POS_OPEN, POS_OPEN));
    send_item(MODE_MOVE, CMD_CLOSE_V1, 4'h0);
    send_item(MODE_CAL, CMD_CLOSE_V1, 4'h0);
    repeat (4) send_item(MODE_TICK, CMD_OPEN_V2, 4'hF);
  endtask

  // Both valves moved; valve 2 rejected on the switches of the ending tick
  task automatic test_calibration();
    send_item(MODE_CAL, CMD_OPEN_V1, valve_switches(POS_MIDDLE, POS_CLOSED));
    send_item(MODE_TICK, CMD_OPEN_V1, 4'hF);
    send_item(MODE_TICK, CMD_OPEN_V1, 4'hF);
    send_item(MODE_TICK, CMD_OPEN_V1, 4'b1110);
    send_item(MODE_TICK, CMD_OPEN_V1, valve_switches(POS_CLOSED, POS_CLOSED));
    send_item(MODE_TICK, CMD_OPEN_V1, 4'b0111);
    send_item(MODE_TICK, CMD_OPEN_V1, 4'h0);
    send_item(MODE_CAL, CMD_OPEN_V2, valve_switches(POS_OPEN, POS_MIDDLE));
    send_item(MODE_TICK, CMD_OPEN_V1, 4'b1100);
    send_item(MODE_TICK, CMD_OPEN_V1, valve_switches(POS_CLOSED, POS_OPEN));
  endtask

  // Longest phase lengths, then zero lengths taking effect mid-sequence
  task automatic test_timing_extremes();
    write_register(REG_BACKOFF, 16'hFFFF);
    write_register(REG_BRAKE, 16'hFFFF);
    write_register(REG_TIMEOUT, 16'hFFFF);
    send_item(MODE_MOVE, CMD_OPEN_V2, 4'b0000);
    send_item(MODE_TICK, CMD_OPEN_V2, 4'hF);
    send_item(MODE_TICK, CMD_OPEN_V2, 4'hF);
    write_register(REG_BACKOFF, 16'd0);
    send_item(MODE_TICK, CMD_OPEN_V2, 4'hF);
    send_item(MODE_TICK, CMD_OPEN_V2, 4'hF);
    write_register(REG_BRAKE, 16'd0);
    send_item(MODE_TICK, CMD_OPEN_V2, 4'hF);
    send_item(MODE_TICK, CMD_OPEN_V2, 4'hF);
    write_register(REG_TIMEOUT, 16'd0);
    send_item(MODE_TICK, CMD_OPEN_V2, 4'hF);
    send_item(MODE_TICK, CMD_OPEN_V2, 4'hF);
    // zero timeout on a fresh drive behaves as one tick
    send_item(MODE_MOVE, CMD_CLOSE_V2, 4'b0100);
    send_item(MODE_TICK, CMD_OPEN_V2, 4'hF);
    send_item(MODE_TICK, CMD_OPEN_V2, 4'hF);
  endtask

  // One command and the ticks that carry it to the end, or a noise transaction
  task automatic run_episode();
    int         kind;
    int         pick;
    int         extra;
    int         ticks;
    logic       stuck;
    logic [3:0] hold;
    logic [3:0] sw;
    kind = $urandom_range(0, 99);
    if (kind < 12) begin
      send_item(2'($urandom_range(0, 3)), 2'($urandom), 4'($urandom));
    end else begin
      if (kind < 70) send_item(MODE_MOVE, 2'($urandom), 4'($urandom));
      else           send_item(MODE_CAL, 2'($urandom), 4'($urandom));
      // stuck switches hold the target switch high, so most such episodes take the timeout path
      stuck = $urandom_range(0, 3) == 0;
      hold  = stuck ? 4'hF : 4'($urandom);
      extra = $urandom_range(0, 3);
      ticks = 0;
      while ((seq_phase != SEQ_IDLE || extra > 0) && ticks < EPISODE_CAP) begin
        if (seq_phase == SEQ_IDLE) extra--;
        pick = $urandom_range(0, 99);
        if (pick < 4) begin
          send_item(2'($urandom_range(1, 3)), 2'($urandom), 4'($urandom));
        end else begin
          sw = (pick < (stuck ? 8 : 30)) ? 4'($urandom) : hold;
          if (!stuck && pick >= 95) hold = 4'($urandom);
          send_item(MODE_TICK, 2'($urandom), sw);
        end
        ticks++;
      end
    end
  endtask

  task automatic test_random_traffic();
    int                goal;
    int                ph;
    logic [TICK_W-1:0] b;
    logic [TICK_W-1:0] k;
    logic [TICK_W-1:0] t;
    goal = sent_items;
    for (ph = 0; ph < RANDOM_PHASES; ph++) begin
      case (ph)
        0: begin
          b = 16'd0; k = 16'd0; t = 16'd1;
          gap_mode = 0; stall_mode = 0;
        end
        1: begin
          b = 16'd1; k = 16'd1; t = 16'd2;
          gap_mode = 1; stall_mode = 1;
        end
        2, 3: begin
          b = 16'($urandom_range(0, 4));
          k = 16'($urandom_range(0, 4));
          t = 16'($urandom_range(1, 8));
          gap_mode   = (ph == 2) ? 1 : 0;
          stall_mode = (ph == 3) ? 1 : 0;
        end
        4: begin
          b = 16'd3; k = 16'd2; t = 16'd12;
          gap_mode = 1; stall_mode = 1;
        end
        default: begin
          b = 16'($urandom_range(0, 10));
          k = 16'($urandom_range(0, 10));
          t = 16'($urandom_range(1, 30));
          gap_mode = 1; stall_mode = 1;
        end
      endcase
      write_register(REG_BACKOFF, b);
      write_register(REG_BRAKE, k);
      write_register(REG_TIMEOUT, t);
      goal += RANDOM_ITEMS / RANDOM_PHASES;
      while (sent_items < goal) run_episode();
    end
  endtask

  initial begin : main
    len_backoff = BACKOFF_RST;
    len_brake   = BRAKE_RST;
    len_timeout = TIMEOUT_RST;
    seq_phase   = SEQ_IDLE;
    seq_count   = '0;
    v1_pos      = POS_MIDDLE;
    v2_pos      = POS_MIDDLE;
    cur_move    = CMD_OPEN_V1;
    cal_stage   = CAL_OFF;
    err_latched = 1'b0;
    cal_done    = 1'b0;
    pin_state   = '0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_idle_and_rejects();
    test_move_outcomes();
    test_calibration();
    test_timing_extremes();
    test_random_traffic();
    wait_for_results();

    if (fail_count == 0) begin
      $display("dual_valve_motor_sequencer: match");
    end else begin
      $display("dual_valve_motor_sequencer: mismatch");
    end
    $finish;
  end

endmodule
